[src/fwsa_pkg.sv]
package fwsa_pkg;

  // Field and register widths.
  localparam int IN_W = 16;
  localparam int CFG_W = 16;
  localparam int POS_W = 12;
  localparam logic [POS_W-1:0] POS_MAX = 12'd4095;
  localparam int LANES = 4;

  // Angle format: pi is 2**ANGLE_BITS.
  localparam int ANGLE_BITS = 27;
  localparam int ZW = ANGLE_BITS + 2;
  localparam int PRESCALE_BITS = 16;
  localparam int ATAN_ENTRIES = 20;
  localparam int ATAN_W = 26;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FRONT_OFFSET = 2'd0;
  localparam logic [1:0] CFG_REAR_OFFSET = 2'd1;
  localparam logic [1:0] CFG_AXLE_WIDTH = 2'd2;

  localparam logic [CFG_W-1:0] FRONT_OFFSET_RESET = 16'd1167;
  localparam logic [CFG_W-1:0] REAR_OFFSET_RESET = 16'd1167;
  localparam logic [CFG_W-1:0] AXLE_WIDTH_RESET = 16'd1855;

  // Steering mode of one command.
  typedef enum logic [1:0] {
    MODE_CENTER = 2'd0,
    MODE_RIGHT = 2'd1,
    MODE_LEFT = 2'd2,
    MODE_ROTATE = 2'd3
  } mode_t;

  // Per-lane control that travels beside the CORDIC data.
  typedef struct packed {
    logic add;
    logic zero_y;
    logic neg_x;
  } side_t;

  // atan(2**-i) in units where pi is 2**ANGLE_BITS, rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_entry(input int idx);
    logic [ATAN_W-1:0] r;
    case (idx)
      0: r = 26'd33554432;
      1: r = 26'd19808338;
      2: r = 26'd10466182;
      3: r = 26'd5312797;
      4: r = 26'd2666708;
      5: r = 26'd1334654;
      6: r = 26'd667490;
      7: r = 26'd333765;
      8: r = 26'd166885;
      9: r = 26'd83443;
      10: r = 26'd41722;
      11: r = 26'd20861;
      12: r = 26'd10430;
      13: r = 26'd5215;
      14: r = 26'd2608;
      15: r = 26'd1304;
      16: r = 26'd652;
      17: r = 26'd326;
      18: r = 26'd163;
      19: r = 26'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/fwsa_prep.sv]
module fwsa_prep #(
  parameter int FRAC_BITS = 12,
  parameter int OP_W = 34,
  parameter int CW = 52
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [fwsa_pkg::IN_W-1:0] linear_velocity,
  input  logic signed [fwsa_pkg::IN_W-1:0] angular_velocity,
  input  logic [fwsa_pkg::CFG_W-1:0] front_wheel_offset,
  input  logic [fwsa_pkg::CFG_W-1:0] rear_wheel_offset,
  input  logic [fwsa_pkg::CFG_W-1:0] axle_width,
  output logic out_valid,
  output logic signed [CW-1:0] out_x [fwsa_pkg::LANES],
  output logic signed [CW-1:0] out_y [fwsa_pkg::LANES],
  output fwsa_pkg::side_t out_side [fwsa_pkg::LANES]
);

  localparam int ONE = 1 << FRAC_BITS;

  // Stage 1: magnitudes and the mode decision.
  logic [15:0] av_c, aw_c;
  logic [25:0] aw_k;
  logic [22:0] av_k;
  logic signed [26:0] v_k;
  logic fast, big_radius, slow;
  fwsa_pkg::mode_t mode_c;

  logic s1_valid;
  logic [15:0] s1_av, s1_aw;
  fwsa_pkg::mode_t s1_mode;

  always_comb begin
    av_c = linear_velocity[15] ? 16'(-linear_velocity) : 16'(linear_velocity);
    aw_c = angular_velocity[15] ? 16'(-angular_velocity) : 16'(angular_velocity);
    aw_k = 26'(aw_c) * 26'd1000;
    av_k = 23'(av_c) * 23'd100;
    v_k = 27'(linear_velocity) * 27'sd1000;
    fast = aw_k > 26'(ONE);
    big_radius = av_k > 23'(aw_c);
    slow = v_k < $signed(27'(ONE));
    if (fast && big_radius) begin
      mode_c = angular_velocity[15] ? fwsa_pkg::MODE_RIGHT : fwsa_pkg::MODE_LEFT;
    end else if (fast && slow) begin
      mode_c = fwsa_pkg::MODE_ROTATE;
    end else begin
      mode_c = fwsa_pkg::MODE_CENTER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_av <= av_c;
      s1_aw <= aw_c;
      s1_mode <= mode_c;
    end
  end

  // Stage 2: distances to the turn center and the scaled wheel offsets.
  logic [31:0] axle_prod, front_prod, rear_prod;
  logic signed [OP_W-1:0] av_scaled;

  logic s2_valid;
  logic signed [OP_W-1:0] s2_far, s2_near, s2_fy, s2_ry;
  fwsa_pkg::mode_t s2_mode;

  always_comb begin
    axle_prod = 32'(axle_width) * 32'(s1_aw);
    front_prod = 32'(front_wheel_offset) * 32'(s1_aw);
    rear_prod = 32'(rear_wheel_offset) * 32'(s1_aw);
    av_scaled = OP_W'(s1_av) <<< (FRAC_BITS + 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_far <= av_scaled + OP_W'(axle_prod);
      s2_near <= av_scaled - OP_W'(axle_prod);
      s2_fy <= OP_W'({front_prod, 1'b0});
      s2_ry <= OP_W'({rear_prod, 1'b0});
      s2_mode <= s1_mode;
    end
  end

  // Stage 3: pick each wheel's vector, fold the left half plane, prescale.
  logic signed [OP_W-1:0] ly [fwsa_pkg::LANES];
  logic signed [OP_W-1:0] lx [fwsa_pkg::LANES];
  logic signed [CW-1:0] nx [fwsa_pkg::LANES];
  logic signed [CW-1:0] ny [fwsa_pkg::LANES];
  fwsa_pkg::side_t ns [fwsa_pkg::LANES];

  always_comb begin
    for (int l = 0; l < fwsa_pkg::LANES; l++) begin
      ns[l].add = 1'b1;
      case (s2_mode)
        fwsa_pkg::MODE_RIGHT: begin
          ly[l] = (l < 2) ? s2_fy : s2_ry;
          lx[l] = (l % 2 == 0) ? s2_far : s2_near;
        end
        fwsa_pkg::MODE_LEFT: begin
          ly[l] = (l < 2) ? s2_fy : s2_ry;
          lx[l] = (l % 2 == 0) ? s2_near : s2_far;
          ns[l].add = 1'b0;
        end
        fwsa_pkg::MODE_ROTATE: begin
          ly[l] = (l < 2) ? OP_W'({front_wheel_offset, 1'b0})
                          : OP_W'({rear_wheel_offset, 1'b0});
          lx[l] = OP_W'(axle_width);
          ns[l].add = (l % 2 == 0);
        end
        default: begin
          ly[l] = '0;
          lx[l] = '0;
        end
      endcase
      ns[l].zero_y = (ly[l] == '0);
      ns[l].neg_x = lx[l][OP_W-1];
      if (lx[l][OP_W-1]) begin
        nx[l] = CW'(ly[l]) <<< fwsa_pkg::PRESCALE_BITS;
        ny[l] = CW'(-lx[l]) <<< fwsa_pkg::PRESCALE_BITS;
      end else begin
        nx[l] = CW'(lx[l]) <<< fwsa_pkg::PRESCALE_BITS;
        ny[l] = CW'(ly[l]) <<< fwsa_pkg::PRESCALE_BITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
    if (en) begin
      for (int l = 0; l < fwsa_pkg::LANES; l++) begin
        out_x[l] <= nx[l];
        out_y[l] <= ny[l];
        out_side[l] <= ns[l];
      end
    end
  end

endmodule

[src/fwsa_cordic.sv]
module fwsa_cordic #(
  parameter int CW = 52,
  parameter int NSTEP = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [CW-1:0] in_x [fwsa_pkg::LANES],
  input  logic signed [CW-1:0] in_y [fwsa_pkg::LANES],
  input  fwsa_pkg::side_t in_side [fwsa_pkg::LANES],
  output logic out_valid,
  output logic signed [fwsa_pkg::ZW-1:0] out_z [fwsa_pkg::LANES],
  output fwsa_pkg::side_t out_side [fwsa_pkg::LANES]
);

  localparam logic signed [fwsa_pkg::ZW-1:0] QUARTER =
    fwsa_pkg::ZW'(1) <<< (fwsa_pkg::ANGLE_BITS - 1);

  logic vld [NSTEP+1];
  logic signed [CW-1:0] xs [fwsa_pkg::LANES][NSTEP+1];
  logic signed [CW-1:0] ys [fwsa_pkg::LANES][NSTEP+1];
  logic signed [fwsa_pkg::ZW-1:0] zs [fwsa_pkg::LANES][NSTEP+1];
  fwsa_pkg::side_t sd [fwsa_pkg::LANES][NSTEP+1];

  assign vld[0] = in_valid;

  // Stage inputs; a folded vector starts from a quarter turn.
  for (genvar l = 0; l < fwsa_pkg::LANES; l++) begin : g_in
    assign xs[l][0] = in_x[l];
    assign ys[l][0] = in_y[l];
    assign zs[l][0] = in_side[l].neg_x ? QUARTER : '0;
    assign sd[l][0] = in_side[l];
  end

  // One vectoring micro-rotation per register stage.
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    localparam logic signed [fwsa_pkg::ZW-1:0] ATAN_I =
      fwsa_pkg::ZW'(fwsa_pkg::atan_entry(i));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    for (genvar l = 0; l < fwsa_pkg::LANES; l++) begin : g_lane
      logic y_pos;
      assign y_pos = !ys[l][i][CW-1] && (ys[l][i] != '0);

      always_ff @(posedge clk) begin
        if (en) begin
          if (y_pos) begin
            xs[l][i+1] <= xs[l][i] + (ys[l][i] >>> i);
            ys[l][i+1] <= ys[l][i] - (xs[l][i] >>> i);
            zs[l][i+1] <= zs[l][i] + ATAN_I;
          end else begin
            xs[l][i+1] <= xs[l][i] - (ys[l][i] >>> i);
            ys[l][i+1] <= ys[l][i] + (xs[l][i] >>> i);
            zs[l][i+1] <= zs[l][i] - ATAN_I;
          end
          sd[l][i+1] <= sd[l][i];
        end
      end
    end
  end

  assign out_valid = vld[NSTEP];
  always_comb begin
    for (int l = 0; l < fwsa_pkg::LANES; l++) begin
      out_z[l] = zs[l][NSTEP];
      out_side[l] = sd[l][NSTEP];
    end
  end

endmodule

[src/fwsa_place.sv]
module fwsa_place #(
  parameter int CENTER_COUNT = 2048
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [fwsa_pkg::ZW-1:0] in_z [fwsa_pkg::LANES],
  input  fwsa_pkg::side_t in_side [fwsa_pkg::LANES],
  output logic out_valid,
  output logic [fwsa_pkg::POS_W-1:0] out_pos [fwsa_pkg::LANES]
);

  localparam int C_W = $clog2(CENTER_COUNT + 1);
  localparam int AW = fwsa_pkg::ANGLE_BITS + 1;
  localparam int D_W = AW + C_W;
  localparam int NUM_W = D_W + 1;
  localparam int P_W = NUM_W - fwsa_pkg::ANGLE_BITS;
  localparam logic [AW-1:0] HALF = AW'(1) << fwsa_pkg::ANGLE_BITS;
  localparam logic [NUM_W-1:0] BASE =
    NUM_W'(CENTER_COUNT) << fwsa_pkg::ANGLE_BITS;

  // Stage A: clamp the angle, handle a zero numerator, scale to counts.
  logic [AW-1:0] zc [fwsa_pkg::LANES];
  logic a_valid;
  logic [D_W-1:0] a_d [fwsa_pkg::LANES];
  logic a_add [fwsa_pkg::LANES];

  always_comb begin
    for (int l = 0; l < fwsa_pkg::LANES; l++) begin
      if (in_side[l].zero_y) begin
        zc[l] = in_side[l].neg_x ? HALF : '0;
      end else if (in_z[l][fwsa_pkg::ZW-1]) begin
        zc[l] = '0;
      end else if (in_z[l] > $signed(fwsa_pkg::ZW'(HALF))) begin
        zc[l] = HALF;
      end else begin
        zc[l] = AW'(in_z[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      for (int l = 0; l < fwsa_pkg::LANES; l++) begin
        a_d[l] <= D_W'(zc[l]) * D_W'(CENTER_COUNT);
        a_add[l] <= in_side[l].add;
      end
    end
  end

  // Stage B: offset from center, truncate, saturate.
  logic [NUM_W-1:0] num [fwsa_pkg::LANES];
  logic [P_W-1:0] pos [fwsa_pkg::LANES];

  always_comb begin
    for (int l = 0; l < fwsa_pkg::LANES; l++) begin
      num[l] = a_add[l] ? BASE + NUM_W'(a_d[l]) : BASE - NUM_W'(a_d[l]);
      pos[l] = num[l][NUM_W-1:fwsa_pkg::ANGLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
    if (en) begin
      for (int l = 0; l < fwsa_pkg::LANES; l++) begin
        if (pos[l] > P_W'(fwsa_pkg::POS_MAX)) begin
          out_pos[l] <= fwsa_pkg::POS_MAX;
        end else begin
          out_pos[l] <= fwsa_pkg::POS_W'(pos[l]);
        end
      end
    end
  end

endmodule

[src/four_wheel_steering_angle_core.sv]
// Four wheel steering angle core.
// Each input word is a velocity command (linear and angular velocity, signed
// Q4.12); each output word holds four steering servo positions, 2048 counts
// meaning straight ahead. Both channels use valid and stall: a word moves on
// a rising edge where valid is high and stall is low.
// Configuration (front offset, rear offset, axle width) is written through the
// cfg channel, index 0 to 2, which is always ready; write it only while idle.
// The pipe runs operand setup, then the CORDIC micro-rotations, then the
// scaling to servo counts. One command is accepted every cycle while the
// pipe is not stalled.
// The four wheel angles run on four parallel CORDIC lanes of the same pipe.
// When the output is stalled with a word waiting, the whole pipe holds and
// in_stall is raised; no word is lost or repeated.
// Synchronous reset empties the pipe and restores the default geometry.
module four_wheel_steering_angle_core #(
  parameter int FRAC_BITS = 12,
  parameter int CORDIC_STEPS = 14,
  parameter int CENTER_COUNT = 2048
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [fwsa_pkg::IN_W-1:0] linear_velocity,
  input  logic signed [fwsa_pkg::IN_W-1:0] angular_velocity,
  output logic out_valid,
  input  logic out_stall,
  output logic [fwsa_pkg::POS_W-1:0] steer_front_left,
  output logic [fwsa_pkg::POS_W-1:0] steer_front_right,
  output logic [fwsa_pkg::POS_W-1:0] steer_rear_left,
  output logic [fwsa_pkg::POS_W-1:0] steer_rear_right,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [fwsa_pkg::CFG_W-1:0] cfg_data
);

  localparam int OP_MAG = (FRAC_BITS + 16 > 31) ? FRAC_BITS + 16 : 31;
  localparam int OP_W = OP_MAG + 2;
  localparam int CW = OP_W + fwsa_pkg::PRESCALE_BITS + 2;
  localparam int NSTEP = (CORDIC_STEPS < fwsa_pkg::ATAN_ENTRIES) ?
                         CORDIC_STEPS : fwsa_pkg::ATAN_ENTRIES;

  // Geometry registers.
  logic [fwsa_pkg::CFG_W-1:0] front_wheel_offset, rear_wheel_offset, axle_width;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_wheel_offset <= fwsa_pkg::FRONT_OFFSET_RESET;
      rear_wheel_offset <= fwsa_pkg::REAR_OFFSET_RESET;
      axle_width <= fwsa_pkg::AXLE_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fwsa_pkg::CFG_FRONT_OFFSET: front_wheel_offset <= cfg_data;
        fwsa_pkg::CFG_REAR_OFFSET: rear_wheel_offset <= cfg_data;
        fwsa_pkg::CFG_AXLE_WIDTH: axle_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipe advances unless a finished word is held at the output.
  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  logic p_valid;
  logic signed [CW-1:0] p_x [fwsa_pkg::LANES];
  logic signed [CW-1:0] p_y [fwsa_pkg::LANES];
  fwsa_pkg::side_t p_side [fwsa_pkg::LANES];

  fwsa_prep #(
    .FRAC_BITS(FRAC_BITS),
    .OP_W(OP_W),
    .CW(CW)
  ) u_prep (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(in_valid),
    .linear_velocity(linear_velocity),
    .angular_velocity(angular_velocity),
    .front_wheel_offset(front_wheel_offset),
    .rear_wheel_offset(rear_wheel_offset),
    .axle_width(axle_width),
    .out_valid(p_valid),
    .out_x(p_x),
    .out_y(p_y),
    .out_side(p_side)
  );

  logic c_valid;
  logic signed [fwsa_pkg::ZW-1:0] c_z [fwsa_pkg::LANES];
  fwsa_pkg::side_t c_side [fwsa_pkg::LANES];

  fwsa_cordic #(
    .CW(CW),
    .NSTEP(NSTEP)
  ) u_cordic (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(p_valid),
    .in_x(p_x),
    .in_y(p_y),
    .in_side(p_side),
    .out_valid(c_valid),
    .out_z(c_z),
    .out_side(c_side)
  );

  logic [fwsa_pkg::POS_W-1:0] pos [fwsa_pkg::LANES];

  fwsa_place #(
    .CENTER_COUNT(CENTER_COUNT)
  ) u_place (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(c_valid),
    .in_z(c_z),
    .in_side(c_side),
    .out_valid(out_valid),
    .out_pos(pos)
  );

  assign steer_front_left = pos[0];
  assign steer_front_right = pos[1];
  assign steer_rear_left = pos[2];
  assign steer_rear_right = pos[3];

  // The input is held off only while a finished word waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked output word");

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word present right after reset");

  // The axle width register changes only through a configuration write.
  a_cfg_only: assert property (@(posedge clk) disable iff (rst)
    !$past(cfg_valid) && !$past(rst) |-> $stable(axle_width))
    else $error("axle width changed without a configuration write");

endmodule

[test/tb_four_wheel_steering_angle_core.sv]
`timescale 1ns / 1ps

module tb_four_wheel_steering_angle_core;

  localparam int LATENCY = 19;

  typedef struct {
    logic signed [15:0] lin;
    logic signed [15:0] ang;
  } command_t;

  typedef struct {
    logic [11:0] fl;
    logic [11:0] fr;
    logic [11:0] rl;
    logic [11:0] rr;
  } servo_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] linear_velocity = '0;
  logic signed [15:0] angular_velocity = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [11:0] steer_front_left, steer_front_right, steer_rear_left, steer_rear_right;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  four_wheel_steering_angle_core dut (.*);

  // Geometry as the predictor sees it.
  longint geo_front = 1167;
  longint geo_rear = 1167;
  longint geo_axle = 1855;

  command_t cmd_queue[$];
  servo_t servo_expected[$];
  int errors = 0;
  bit hold_off = 1'b0;
  bit sender_on = 1'b0;

  // Clock generation.
  initial begin
    forever #1 clk = ~clk;
  end

  // Arithmetic shift right on wide signed values.
  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_tab(int i);
    longint t[20] = '{33554432, 19808338, 10466182, 5312797, 2666708, 1334654, 667490,
                      333765, 166885, 83443, 41722, 20861, 10430, 5215, 2608, 1304,
                      652, 326, 163, 81};
    return t[i];
  endfunction

  // CORDIC vectoring angle of (x, y), y >= 0, with pi = 2**27.
  function automatic longint wheel_angle(longint y, longint x);
    longint z, t, nx, ny;
    z = 0;
    if (y == 0) return (x < 0) ? (longint'(1) << 27) : 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = longint'(1) << 26;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < 14; i++) begin
      if (y > 0) begin
        nx = x + shr(y, i);
        ny = y - shr(x, i);
        z += atan_tab(i);
      end else begin
        nx = x - shr(y, i);
        ny = y + shr(x, i);
        z -= atan_tab(i);
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    if (z > (longint'(1) << 27)) z = longint'(1) << 27;
    return z;
  endfunction

  // Angle to servo count around center, floored and saturated.
  function automatic logic [11:0] servo_count(longint z, bit add);
    longint base, d, num, p;
    base = longint'(2048) << 27;
    d = z * 2048;
    num = add ? base + d : (d > base ? 0 : base - d);
    p = num >>> 27;
    return (p > 4095) ? 12'd4095 : p[11:0];
  endfunction

  function automatic servo_t steering_predict(command_t c);
    servo_t r;
    longint v, w, av, aw, far_x, near_x, fy, ry, fz, rz;
    bit fast, big_radius;
    v = longint'(c.lin);
    w = longint'(c.ang);
    av = v < 0 ? -v : v;
    aw = w < 0 ? -w : w;
    fast = 1000 * aw > 4096;
    big_radius = 100 * av > aw;
    if (fast && big_radius) begin
      far_x = 2 * av * 4096 + geo_axle * aw;
      near_x = 2 * av * 4096 - geo_axle * aw;
      fy = 2 * geo_front * aw;
      ry = 2 * geo_rear * aw;
      if (w < 0) begin
        r.fl = servo_count(wheel_angle(fy, far_x), 1'b1);
        r.fr = servo_count(wheel_angle(fy, near_x), 1'b1);
        r.rl = servo_count(wheel_angle(ry, far_x), 1'b1);
        r.rr = servo_count(wheel_angle(ry, near_x), 1'b1);
      end else begin
        r.fl = servo_count(wheel_angle(fy, near_x), 1'b0);
        r.fr = servo_count(wheel_angle(fy, far_x), 1'b0);
        r.rl = servo_count(wheel_angle(ry, near_x), 1'b0);
        r.rr = servo_count(wheel_angle(ry, far_x), 1'b0);
      end
    end else if (fast && 1000 * v < 4096) begin
      fz = wheel_angle(2 * geo_front, geo_axle);
      rz = wheel_angle(2 * geo_rear, geo_axle);
      r.fl = servo_count(fz, 1'b1);
      r.fr = servo_count(fz, 1'b0);
      r.rl = servo_count(rz, 1'b1);
      r.rr = servo_count(rz, 1'b0);
    end else begin
      r.fl = 12'd2048;
      r.fr = 12'd2048;
      r.rl = 12'd2048;
      r.rr = 12'd2048;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: bursts of words separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  // Record each accepted input word and its expected output.
  command_t cur;
  bit in_taken = 1'b0;
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      servo_expected.push_back(steering_predict(cur));
    end
  end

  always @(negedge clk) begin
    if (rst || !sender_on) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // Hold the stalled word.
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (cmd_queue.size() > 0) begin
      cur = cmd_queue.pop_front();
      linear_velocity <= cur.lin;
      angular_velocity <= cur.ang;
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 20);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall pattern, with a forced long hold-off.
  int stall_mode = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Monitor: compare each word taken from the output.
  servo_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (servo_expected.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = servo_expected.pop_front();
        if (steer_front_left !== want.fl)
          report_mismatch("front left", int'(steer_front_left), int'(want.fl));
        if (steer_front_right !== want.fr)
          report_mismatch("front right", int'(steer_front_right), int'(want.fr));
        if (steer_rear_left !== want.rl)
          report_mismatch("rear left", int'(steer_rear_left), int'(want.rl));
        if (steer_rear_right !== want.rr)
          report_mismatch("rear right", int'(steer_rear_right), int'(want.rr));
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      fwsa_pkg::CFG_FRONT_OFFSET: geo_front = longint'(val);
      fwsa_pkg::CFG_REAR_OFFSET: geo_rear = longint'(val);
      default: geo_axle = longint'(val);
    endcase
  endtask

  task automatic add_cmd(logic [15:0] v, logic [15:0] w);
    command_t c;
    c.lin = v;
    c.ang = w;
    cmd_queue.push_back(c);
  endtask

  // Random command, weighted toward turns and decision boundaries.
  task automatic add_random_cmd();
    logic [15:0] v, w;
    case ($urandom_range(0, 7))
      0: begin v = 16'($urandom); w = 16'($urandom); end
      1: begin v = 16'($urandom_range(0, 8)); w = 16'($urandom); end
      2: begin v = 16'($urandom); w = 16'($urandom_range(0, 10)) - 16'd5; end
      3: begin v = -16'($urandom_range(0, 3000)); w = 16'($urandom); end
      default: begin
        v = 16'($urandom_range(1, 32767));
        if ($urandom_range(0, 1)) v = -v;
        w = 16'($urandom_range(5, 32767));
        if ($urandom_range(0, 1)) w = -w;
      end
    endcase
    add_cmd(v, w);
  endtask

  task automatic run_phase();
    sender_on = 1'b1;
    while (cmd_queue.size() > 0 || servo_expected.size() > 0 || in_valid) @(posedge clk);
    sender_on = 1'b0;
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Stimulus and configuration sequence.
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words: extremes, every steering mode, boundary cases.
    add_cmd(16'sd0, 16'sd0);
    add_cmd(16'sd32767, 16'sd32767);
    add_cmd(16'sd32767, -16'sd32768);
    add_cmd(-16'sd32768, 16'sd32767);
    add_cmd(-16'sd32768, -16'sd32768);
    add_cmd(16'sd4096, -16'sd4096);
    add_cmd(16'sd4096, 16'sd4096);
    add_cmd(16'sd0, 16'sd4096);
    add_cmd(16'sd0, -16'sd4096);
    add_cmd(16'sd4, 16'sd4096);
    add_cmd(16'sd5, 16'sd500);
    add_cmd(16'sd4096, 16'sd4);
    add_cmd(16'sd4096, 16'sd5);
    add_cmd(16'sd4096, -16'sd5);
    add_cmd(-16'sd4096, 16'sd2000);
    add_cmd(16'sd1, 16'sd100);
    add_cmd(16'sd1, 16'sd101);
    add_cmd(16'sd200, 16'sd32767);
    add_cmd(-16'sd100, -16'sd20000);
    add_cmd(16'sd4, -16'sd4);
    run_phase();

    // Random phases across register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(fwsa_pkg::CFG_FRONT_OFFSET, 16'd0);
          write_reg(fwsa_pkg::CFG_REAR_OFFSET, 16'hFFFF);
          write_reg(fwsa_pkg::CFG_AXLE_WIDTH, 16'd0);
        end
        1: begin
          write_reg(fwsa_pkg::CFG_FRONT_OFFSET, 16'hFFFF);
          write_reg(fwsa_pkg::CFG_REAR_OFFSET, 16'd0);
          write_reg(fwsa_pkg::CFG_AXLE_WIDTH, 16'hFFFF);
        end
        5: begin
          write_reg(fwsa_pkg::CFG_FRONT_OFFSET, 16'd1167);
          write_reg(fwsa_pkg::CFG_REAR_OFFSET, 16'd1167);
          write_reg(fwsa_pkg::CFG_AXLE_WIDTH, 16'd1855);
        end
        default: begin
          write_reg(fwsa_pkg::CFG_FRONT_OFFSET, 16'($urandom));
          write_reg(fwsa_pkg::CFG_REAR_OFFSET, 16'($urandom));
          write_reg(fwsa_pkg::CFG_AXLE_WIDTH, 16'($urandom));
        end
      endcase
      for (int i = 0; i < 120; i++) add_random_cmd();
      if (ph == 2) begin
        fork
          run_phase();
          begin
            @(negedge clk);
            hold_off = 1'b1;
            repeat (80) @(posedge clk);
            hold_off = 1'b0;
          end
        join
      end else begin
        run_phase();
      end
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #200000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
